// File: hw/rtl/text_console_renderer_core_assert.svh
// Assertion macros used by the console renderer RTL.
`ifndef TEXT_CONSOLE_RENDERER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_RENDERER_CORE_ASSERT_SVH

// Check a condition at every rising clock edge outside reset.
`define TCR_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define TCR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define TCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tcr_pkg.sv
// Types and constants of the text console renderer.
package tcr_pkg;

    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 11;
    localparam int CELL_W  = 16;
    localparam int X_W     = 7;
    localparam int Y_W     = 5;

    localparam logic [MODE_W-1:0] MODE_CHAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ATTR  = 2'd3;

    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h1B;
    localparam logic [BYTE_W-1:0] BS_BYTE    = 8'h08;
    localparam logic [BYTE_W-1:0] TAB_BYTE   = 8'h09;
    localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0A;
    localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0D;
    localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_LAST = 8'h7F;

    localparam logic [CELL_W-1:0] HIGH_NIBBLE_MASK = 16'hF000;
    localparam logic [CELL_W-1:0] RESET_ATTR       = 16'h0F00;

    localparam int TAB_STEP    = 8;
    localparam int TAB_SHIFT   = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRINT,
        OP_BS,
        OP_TAB,
        OP_CR,
        OP_LF,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] attr;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_COPY,
        ST_FILL
    } back_state_t;

    function automatic logic [CELL_W-1:0] blank_cell(input logic [CELL_W-1:0] attr);
        return attr | {{(CELL_W-BYTE_W){1'b0}}, BLANK_CHAR};
    endfunction

endpackage

// File: hw/rtl/tcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/tcr_queue.sv
// Short command queue between the front and back parts.
module tcr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_en,
    input  tcr_pkg::cmd_t din,
    output logic          full,
    output tcr_pkg::cmd_t dout,
    output logic          empty,
    input  logic          pop_en
);

    import tcr_pkg::*;

    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CNTW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push_en && !full;
    assign do_pop  = pop_en && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: hw/rtl/tcr_front.sv
// Front part: accepts items, tracks escape and attribute, classifies bytes.
module tcr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [tcr_pkg::MODE_W-1:0]    mode,
    input  logic [tcr_pkg::BYTE_W-1:0]    byte_in,
    input  logic [tcr_pkg::ADDR_W-1:0]    cell_address,
    input  logic [tcr_pkg::CELL_W-1:0]    attr_value,
    input  logic                          init_busy,
    input  logic                          q_full,
    output logic                          q_push,
    output tcr_pkg::cmd_t                 q_cmd
);

    import tcr_pkg::*;

    logic              esc_reg, esc_next;
    logic [CELL_W-1:0] attr_reg, attr_next;
    logic              accept;

    assign full   = q_full || init_busy;
    assign accept = push && !full;
    assign q_push = accept;

    always_comb
    begin
        q_cmd.op   = OP_NOP;
        q_cmd.ch   = byte_in;
        q_cmd.addr = cell_address;
        q_cmd.attr = attr_reg;
        esc_next   = esc_reg;
        attr_next  = attr_reg;
        unique case (mode)
            MODE_CHAR:
            begin
                if (esc_reg)
                begin
                    attr_next = {byte_in, {BYTE_W{1'b0}}} | (attr_reg & HIGH_NIBBLE_MASK);
                    esc_next  = 1'b0;
                end
                else if (byte_in == ESC_BYTE)
                begin
                    esc_next = 1'b1;
                end
                else if (byte_in == BS_BYTE)
                begin
                    q_cmd.op = OP_BS;
                end
                else if (byte_in == TAB_BYTE)
                begin
                    q_cmd.op = OP_TAB;
                end
                else if (byte_in == CR_BYTE)
                begin
                    q_cmd.op = OP_CR;
                end
                else if (byte_in == LF_BYTE)
                begin
                    q_cmd.op = OP_LF;
                end
                else if (byte_in >= BLANK_CHAR && byte_in <= PRINT_LAST)
                begin
                    q_cmd.op = OP_PRINT;
                end
            end
            MODE_READ:
            begin
                q_cmd.op = OP_READ;
            end
            MODE_CLEAR:
            begin
                q_cmd.op = OP_CLEAR;
            end
            MODE_ATTR:
            begin
                attr_next = attr_value;
            end
            default:
            begin
                q_cmd.op = OP_NOP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg  <= 1'b0;
            attr_reg <= RESET_ATTR;
        end
        else if (accept)
        begin
            esc_reg  <= esc_next;
            attr_reg <= attr_next;
        end
    end

endmodule

// File: hw/rtl/tcr_back.sv
// Back part: cursor, cell writes, reads, clear, scroll and the result register.
`include "text_console_renderer_core_assert.svh"

module tcr_back #(
    parameter int COLUMNS = 80,
    parameter int LINES   = 25,
    localparam int CELL_COUNT = COLUMNS * LINES,
    localparam int AW = $clog2(CELL_COUNT)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tcr_pkg::cmd_t              cmd,
    input  logic                       q_empty,
    output logic                       q_pop,
    output logic                       init_busy,
    output logic                       ram_we,
    output logic [AW-1:0]              ram_waddr,
    output logic [tcr_pkg::CELL_W-1:0] ram_wdata,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_raddr,
    input  logic [tcr_pkg::CELL_W-1:0] ram_rdata,
    input  logic                       pop,
    output logic                       empty,
    output logic [tcr_pkg::X_W-1:0]    cursor_x,
    output logic [tcr_pkg::Y_W-1:0]    cursor_y,
    output logic [tcr_pkg::CELL_W-1:0] cell_data,
    output logic                       scrolled
);

    import tcr_pkg::*;

    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int IW         = $clog2(CELL_COUNT + 1);
    localparam int COPY_COUNT = COLUMNS * (LINES - 1);

    back_state_t       state_reg, state_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [CELL_W-1:0] fill_attr_reg, fill_attr_next;
    logic              range_reg, range_next;
    logic              out_valid_reg, out_valid_next;
    logic [CW-1:0]     out_x_reg, out_x_next;
    logic [RW-1:0]     out_y_reg, out_y_next;
    logic [CELL_W-1:0] out_data_reg, out_data_next;
    logic              out_scr_reg, out_scr_next;
    logic              out_load;
    logic              take;
    logic [CW:0]       col_t;
    logic [RW:0]       row_t;
    logic [CW:0]       tab_sum;
    logic              need_scroll;
    logic [CW-1:0]     step_col;
    logic [RW-1:0]     step_row;
    logic [AW-1:0]     print_addr;

    assign take      = (state_reg == ST_IDLE) && !q_empty && (!out_valid_reg || pop);
    assign q_pop     = take;
    assign init_busy = (state_reg == ST_INIT);

    assign tab_sum    = {1'b0, col_reg} + (CW+1)'(TAB_STEP);
    assign print_addr = AW'(row_reg * COLUMNS + col_reg);

    always_comb
    begin
        col_t = {1'b0, col_reg};
        row_t = {1'b0, row_reg};
        unique case (cmd.op)
            OP_PRINT:
            begin
                col_t = {1'b0, col_reg} + 1'b1;
            end
            OP_BS:
            begin
                if (col_reg != '0)
                begin
                    col_t = {1'b0, col_reg} - 1'b1;
                end
                else if (row_reg != '0)
                begin
                    col_t = (CW+1)'(COLUMNS - 1);
                    row_t = {1'b0, row_reg} - 1'b1;
                end
            end
            OP_TAB:
            begin
                col_t = {tab_sum[CW:TAB_SHIFT], {TAB_SHIFT{1'b0}}};
            end
            OP_CR:
            begin
                col_t = '0;
            end
            OP_LF:
            begin
                col_t = '0;
                row_t = {1'b0, row_reg} + 1'b1;
            end
            default:
            begin
                col_t = {1'b0, col_reg};
            end
        endcase
        if (col_t >= COLUMNS)
        begin
            col_t = '0;
            row_t = row_t + 1'b1;
        end
        need_scroll = (row_t >= LINES);
        step_col    = CW'(col_t);
        step_row    = need_scroll ? RW'(LINES - 1) : RW'(row_t);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (idx_reg == IW'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    if (cmd.op == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (cmd.op == OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (need_scroll)
                    begin
                        state_next = ST_COPY;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (idx_reg == IW'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                if (idx_reg == IW'(COPY_COUNT))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (idx_reg == IW'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        fill_attr_next = fill_attr_reg;
        range_next     = range_reg;
        out_load       = 1'b0;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_data_next  = out_data_reg;
        out_scr_next   = out_scr_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = blank_cell(RESET_ATTR);
                idx_next  = (idx_reg == IW'(CELL_COUNT - 1)) ? '0 : idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    if (cmd.op == OP_READ)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = AW'(cmd.addr);
                        range_next = (cmd.addr < CELL_COUNT);
                    end
                    else if (cmd.op == OP_CLEAR)
                    begin
                        fill_attr_next = cmd.attr;
                        idx_next       = '0;
                    end
                    else
                    begin
                        if (cmd.op == OP_PRINT)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = print_addr;
                            ram_wdata = {{(CELL_W-BYTE_W){1'b0}}, cmd.ch} | cmd.attr;
                        end
                        col_next = step_col;
                        row_next = step_row;
                        if (need_scroll)
                        begin
                            fill_attr_next = cmd.attr;
                            idx_next       = '0;
                        end
                        else
                        begin
                            out_load      = 1'b1;
                            out_x_next    = step_col;
                            out_y_next    = step_row;
                            out_data_next = '0;
                            out_scr_next  = 1'b0;
                        end
                    end
                end
            end
            ST_READ:
            begin
                out_load      = 1'b1;
                out_x_next    = col_reg;
                out_y_next    = row_reg;
                out_data_next = range_reg ? ram_rdata : '0;
                out_scr_next  = 1'b0;
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = blank_cell(fill_attr_reg);
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IW'(CELL_COUNT - 1))
                begin
                    col_next      = '0;
                    row_next      = '0;
                    out_load      = 1'b1;
                    out_x_next    = '0;
                    out_y_next    = '0;
                    out_data_next = '0;
                    out_scr_next  = 1'b0;
                end
            end
            ST_COPY:
            begin
                if (idx_reg < IW'(COPY_COUNT))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(idx_reg + COLUMNS);
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(idx_reg - 1'b1);
                    ram_wdata = ram_rdata;
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = blank_cell(fill_attr_reg);
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IW'(CELL_COUNT - 1))
                begin
                    out_load      = 1'b1;
                    out_x_next    = col_reg;
                    out_y_next    = row_reg;
                    out_data_next = '0;
                    out_scr_next  = 1'b1;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_attr_reg <= fill_attr_next;
        range_reg     <= range_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_data_reg  <= out_data_next;
        out_scr_reg   <= out_scr_next;
    end

    assign empty     = !out_valid_reg;
    assign cursor_x  = X_W'(out_x_reg);
    assign cursor_y  = Y_W'(out_y_reg);
    assign cell_data = out_data_reg;
    assign scrolled  = out_scr_reg;

    `TCR_ASSERT_IMPL(a_take_slot_free, q_pop, !out_valid_reg || pop, "result slot busy")
    `TCR_ASSERT_IMPL(a_load_slot_free, out_load, !out_valid_reg || pop, "result overwritten")
    `TCR_ASSERT(a_cursor_range, (col_reg < COLUMNS) && (row_reg < LINES), "cursor off screen")
    `TCR_ASSERT_IMPL(a_pend_in_copy, pend_reg, state_reg == ST_COPY, "copy write outside scroll")
    `TCR_ASSERT_NEXT(a_scroll_reports, out_load && out_scr_next, !empty && scrolled, "scroll lost")

endmodule

// File: hw/rtl/text_console_renderer_core.sv
// Top level of the text console renderer.
//
//  channel  | handshake         | payload
//  ---------+-------------------+----------------------------------------------
//  input    | push / full       | mode, byte_in, cell_address, attr_value
//  result   | empty / pop       | cursor_x, cursor_y, cell_data, scrolled
//
// Cursor and character items are handled in ST_IDLE; a cell read also passes ST_READ (RAM read port).
// Clear sweeps every cell in ST_CLEAR, one cell write per cycle on the RAM write port.
// A scroll copies the rows up in ST_COPY, then blanks the last line in ST_FILL.
// After reset the cell RAM is swept to blanks in ST_INIT while full is held high.
// A two-entry queue sits between front and back; one result register feeds the result side.
module text_console_renderer_core #(
    parameter int COLUMNS = 80,
    parameter int LINES   = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [tcr_pkg::MODE_W-1:0] mode,
    input  logic [tcr_pkg::BYTE_W-1:0] byte_in,
    input  logic [tcr_pkg::ADDR_W-1:0] cell_address,
    input  logic [tcr_pkg::CELL_W-1:0] attr_value,
    output logic                       empty,
    input  logic                       pop,
    output logic [tcr_pkg::X_W-1:0]    cursor_x,
    output logic [tcr_pkg::Y_W-1:0]    cursor_y,
    output logic [tcr_pkg::CELL_W-1:0] cell_data,
    output logic                       scrolled
);

    import tcr_pkg::*;

    localparam int CELL_COUNT = COLUMNS * LINES;
    localparam int AW         = $clog2(CELL_COUNT);

    logic              init_busy;
    logic              q_full;
    logic              q_push;
    cmd_t              q_in_cmd;
    cmd_t              q_out_cmd;
    logic              q_empty;
    logic              q_pop;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tcr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .byte_in      (byte_in),
        .cell_address (cell_address),
        .attr_value   (attr_value),
        .init_busy    (init_busy),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_in_cmd)
    );

    tcr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (q_push),
        .din     (q_in_cmd),
        .full    (q_full),
        .dout    (q_out_cmd),
        .empty   (q_empty),
        .pop_en  (q_pop)
    );

    tcr_back #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_out_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .pop       (pop),
        .empty     (empty),
        .cursor_x  (cursor_x),
        .cursor_y  (cursor_y),
        .cell_data (cell_data),
        .scrolled  (scrolled)
    );

    tcr_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
